// ===== hdl/avc_pkg.sv =====
// ----------------------------------------------------------------------------
// avc_pkg
// Shared types, widths and the byte-mask decode function of the attribute value cache.
// ----------------------------------------------------------------------------
`default_nettype none

package avc_pkg;

  localparam int DEF_CACHE_ENTRIES = 32;

  localparam int REQ_W   = 2;
  localparam int DEV_W   = 64;
  localparam int EP_W    = 8;
  localparam int CL_W    = 16;
  localparam int ATTR_W  = 16;
  localparam int TYPE_W  = 8;
  localparam int VALUE_W = 64;
  localparam int STAMP_W = 32;
  // At most four value bytes are ever written, so only the low word is kept.
  localparam int STORE_W = 32;

  localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  localparam logic [TYPE_W-1:0] TC_BOOL   = 8'h10;
  localparam logic [TYPE_W-1:0] TC_MAP8   = 8'h18;
  localparam logic [TYPE_W-1:0] TC_MAP16  = 8'h19;
  localparam logic [TYPE_W-1:0] TC_UINT8  = 8'h20;
  localparam logic [TYPE_W-1:0] TC_UINT16 = 8'h21;
  localparam logic [TYPE_W-1:0] TC_UINT24 = 8'h22;
  localparam logic [TYPE_W-1:0] TC_UINT32 = 8'h23;
  localparam logic [TYPE_W-1:0] TC_INT8   = 8'h28;
  localparam logic [TYPE_W-1:0] TC_INT16  = 8'h29;
  localparam logic [TYPE_W-1:0] TC_INT24  = 8'h2A;
  localparam logic [TYPE_W-1:0] TC_INT32  = 8'h2B;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic                valid;
    logic [DEV_W-1:0]    device;
    logic [EP_W-1:0]     endpoint;
    logic [CL_W-1:0]     cluster;
    logic [ATTR_W-1:0]   attribute;
    logic [TYPE_W-1:0]   etype;
    logic [STORE_W-1:0]  value;
    logic [STAMP_W-1:0]  stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Mask of the value bytes that a type code compares and rewrites.
  function automatic logic [STORE_W-1:0] byte_mask(input logic [TYPE_W-1:0] t);
    logic [STORE_W-1:0] m;
    unique case (t) inside
      TC_MAP16, TC_UINT16, TC_INT16: m = 32'h0000_FFFF;
      TC_UINT24, TC_INT24:           m = 32'h00FF_FFFF;
      TC_UINT32, TC_INT32:           m = 32'hFFFF_FFFF;
      default:                       m = 32'h0000_00FF;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/avc_ram.sv =====
// ----------------------------------------------------------------------------
// avc_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module avc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/attribute_value_cache_top.sv =====
// ----------------------------------------------------------------------------
// attribute_value_cache_top
// Fully associative attribute value cache with oldest-stamp replacement.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low. Update
// stores the low value bytes selected by the type code under the key
// (device, endpoint, cluster, attribute), lookup reports presence, and clear
// frees every entry of one device address. Exactly one result follows each
// request: out_strobe is high for one cycle with out_hit and out_changed.
//
// All entries live in one RAM with a registered read. Every update, lookup
// or clear walks the whole table, one entry read per cycle, and then passes
// through a drain state and a decide state; an update then also does the
// read-modify-write of the chosen entry through the same RAM, reading it in
// the decide state and writing it in the write state. The unused request code
// answers on the next cycle. A new request can be taken in the cycle that
// its predecessor's result is shown. The receiver cannot stall.
//
// After reset the block zeroes the RAM, one entry per cycle, and holds busy
// high until every entry is zeroed, before taking the first request.
// ----------------------------------------------------------------------------
`default_nettype none

module attribute_value_cache_top
  import avc_pkg::*;
#(
  parameter int CACHE_ENTRIES = DEF_CACHE_ENTRIES
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [REQ_W-1:0]   in_req_type,
  input  wire logic [DEV_W-1:0]   in_device_addr,
  input  wire logic [EP_W-1:0]    in_endpoint,
  input  wire logic [CL_W-1:0]    in_cluster,
  input  wire logic [ATTR_W-1:0]  in_attribute,
  input  wire logic [TYPE_W-1:0]  in_type_code,
  input  wire logic [VALUE_W-1:0] in_value_bytes,
  input  wire logic [STAMP_W-1:0] in_now_ms,
  output logic                    out_strobe,
  output logic                    out_hit,
  output logic                    out_changed
);

  localparam int IDX_W = $clog2(CACHE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

  state_t state_r, state_nxt;

  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;

  logic [REQ_W-1:0]   req_r, req_nxt;
  logic [DEV_W-1:0]   dev_r, dev_nxt;
  logic [EP_W-1:0]    ep_r, ep_nxt;
  logic [CL_W-1:0]    cl_r, cl_nxt;
  logic [ATTR_W-1:0]  at_r, at_nxt;
  logic [TYPE_W-1:0]  ty_r, ty_nxt;
  logic [STORE_W-1:0] val_r, val_nxt;
  logic [STAMP_W-1:0] now_r, now_nxt;

  logic               found_r, found_nxt;
  logic [IDX_W-1:0]   match_idx_r, match_idx_nxt;
  logic               free_found_r, free_found_nxt;
  logic [IDX_W-1:0]   free_idx_r, free_idx_nxt;
  logic [STAMP_W-1:0] best_r, best_nxt;
  logic [IDX_W-1:0]   min_idx_r, min_idx_nxt;
  logic               freed_r, freed_nxt;
  logic [IDX_W-1:0]   tgt_r, tgt_nxt;

  logic out_strobe_r, out_strobe_nxt;
  logic out_hit_r, out_hit_nxt;
  logic out_changed_r, out_changed_nxt;

  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  entry_t             ram_wdata, ram_rdata;

  logic               cnt_last;
  logic               key_eq;
  logic [STORE_W-1:0] mask;
  logic [STORE_W-1:0] new_value;

  assign cnt_last = (cnt_r == LAST_IDX);
  assign mask     = byte_mask(ty_r);
  assign key_eq   = ram_rdata.valid && (ram_rdata.device == dev_r) &&
                    (ram_rdata.endpoint == ep_r) && (ram_rdata.cluster == cl_r) &&
                    (ram_rdata.attribute == at_r);
  assign new_value = (ram_rdata.value & ~mask) | (val_r & mask);

  avc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CACHE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (cnt_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start && (in_req_type == REQ_UPDATE || in_req_type == REQ_LOOKUP ||
                      in_req_type == REQ_CLEAR)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        state_nxt = (req_r == REQ_UPDATE) ? ST_WRITE : ST_IDLE;
      end
      ST_WRITE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, RAM control and result.
  always_comb begin
    cnt_nxt         = cnt_r;
    rd_vld_nxt      = 1'b0;
    rd_idx_nxt      = rd_idx_r;
    req_nxt         = req_r;
    dev_nxt         = dev_r;
    ep_nxt          = ep_r;
    cl_nxt          = cl_r;
    at_nxt          = at_r;
    ty_nxt          = ty_r;
    val_nxt         = val_r;
    now_nxt         = now_r;
    found_nxt       = found_r;
    match_idx_nxt   = match_idx_r;
    free_found_nxt  = free_found_r;
    free_idx_nxt    = free_idx_r;
    best_nxt        = best_r;
    min_idx_nxt     = min_idx_r;
    freed_nxt       = freed_r;
    tgt_nxt         = tgt_r;
    out_strobe_nxt  = 1'b0;
    out_hit_nxt     = out_hit_r;
    out_changed_nxt = out_changed_r;
    ram_re          = 1'b0;
    ram_raddr       = cnt_r;
    ram_we          = 1'b0;
    ram_waddr       = rd_idx_r;
    ram_wdata       = '0;

    unique case (state_r)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        cnt_nxt   = cnt_last ? '0 : cnt_r + 1'b1;
      end
      ST_IDLE: begin
        if (start) begin
          req_nxt        = in_req_type;
          dev_nxt        = in_device_addr;
          ep_nxt         = in_endpoint;
          cl_nxt         = in_cluster;
          at_nxt         = in_attribute;
          ty_nxt         = in_type_code;
          val_nxt        = in_value_bytes[STORE_W-1:0];
          now_nxt        = in_now_ms;
          found_nxt      = 1'b0;
          match_idx_nxt  = '0;
          free_found_nxt = 1'b0;
          free_idx_nxt   = '0;
          best_nxt       = '1;
          min_idx_nxt    = '0;
          freed_nxt      = 1'b0;
          cnt_nxt        = '0;
          if (!(in_req_type == REQ_UPDATE || in_req_type == REQ_LOOKUP ||
                in_req_type == REQ_CLEAR)) begin
            out_strobe_nxt  = 1'b1;
            out_hit_nxt     = 1'b0;
            out_changed_nxt = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        ram_re     = 1'b1;
        ram_raddr  = cnt_r;
        rd_vld_nxt = 1'b1;
        rd_idx_nxt = cnt_r;
        cnt_nxt    = cnt_last ? '0 : cnt_r + 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_DECIDE: begin
        if (req_r == REQ_UPDATE) begin
          // A hit rewrites its own entry; a miss takes a free one or the oldest.
          if (found_r) begin
            tgt_nxt = match_idx_r;
          end else if (free_found_r) begin
            tgt_nxt = free_idx_r;
          end else begin
            tgt_nxt = min_idx_r;
          end
          ram_re    = 1'b1;
          ram_raddr = tgt_nxt;
        end else begin
          out_strobe_nxt  = 1'b1;
          out_hit_nxt     = (req_r == REQ_LOOKUP) ? found_r : freed_r;
          out_changed_nxt = 1'b0;
        end
      end
      ST_WRITE: begin
        ram_we              = 1'b1;
        ram_waddr           = tgt_r;
        ram_wdata.valid     = 1'b1;
        ram_wdata.device    = dev_r;
        ram_wdata.endpoint  = ep_r;
        ram_wdata.cluster   = cl_r;
        ram_wdata.attribute = at_r;
        ram_wdata.etype     = found_r ? ram_rdata.etype : ty_r;
        ram_wdata.value     = new_value;
        ram_wdata.stamp     = now_r;
        out_strobe_nxt      = 1'b1;
        out_hit_nxt         = found_r;
        out_changed_nxt     = found_r ? (((ram_rdata.value ^ val_r) & mask) != '0) : 1'b1;
      end
      default: begin
      end
    endcase

    // Evaluate the entry read in the previous cycle of the walk.
    if (rd_vld_r) begin
      if (key_eq && !found_r) begin
        found_nxt     = 1'b1;
        match_idx_nxt = rd_idx_r;
      end
      if (!ram_rdata.valid && !free_found_r) begin
        free_found_nxt = 1'b1;
        free_idx_nxt   = rd_idx_r;
      end
      if (ram_rdata.stamp < best_r) begin
        best_nxt    = ram_rdata.stamp;
        min_idx_nxt = rd_idx_r;
      end
      // A clear zeroes each entry of the device right behind the read.
      if (req_r == REQ_CLEAR && ram_rdata.valid && ram_rdata.device == dev_r) begin
        ram_we    = 1'b1;
        ram_waddr = rd_idx_r;
        ram_wdata = '0;
        freed_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      cnt_r        <= '0;
      rd_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      rd_vld_r     <= rd_vld_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r      <= rd_idx_nxt;
    req_r         <= req_nxt;
    dev_r         <= dev_nxt;
    ep_r          <= ep_nxt;
    cl_r          <= cl_nxt;
    at_r          <= at_nxt;
    ty_r          <= ty_nxt;
    val_r         <= val_nxt;
    now_r         <= now_nxt;
    found_r       <= found_nxt;
    match_idx_r   <= match_idx_nxt;
    free_found_r  <= free_found_nxt;
    free_idx_r    <= free_idx_nxt;
    best_r        <= best_nxt;
    min_idx_r     <= min_idx_nxt;
    freed_r       <= freed_nxt;
    tgt_r         <= tgt_nxt;
    out_hit_r     <= out_hit_nxt;
    out_changed_r <= out_changed_nxt;
  end

  assign busy        = (state_r != ST_IDLE);
  assign out_strobe  = out_strobe_r;
  assign out_hit     = out_hit_r;
  assign out_changed = out_changed_r;

endmodule

`default_nettype wire
